### design/bir_pkg.sv
// bir_pkg: shared types and constants for the bicubic image resampler
// no dependencies
`timescale 1ns / 1ps
package bir_pkg;
  localparam int ChBits = 16;
  localparam int FracBits = 16;
  localparam logic MODE_LOAD = 1'b0;
  localparam logic MODE_SAMPLE = 1'b1;

  localparam logic [1:0] CFG_SRC_W = 2'd0;
  localparam logic [1:0] CFG_SRC_H = 2'd1;
  localparam logic [1:0] CFG_DST_W = 2'd2;
  localparam logic [1:0] CFG_DST_H = 2'd3;

  // one queued command from front to back
  typedef struct packed {
    logic        load;
    logic [15:0] addr;
    logic [63:0] pix;
    logic [7:0]  xs0;   // last source column (sw - 1), clamp limit in back
    logic [7:0]  ys0;
    logic signed [13:0] xi;
    logic signed [13:0] yi;
    logic [15:0] xt;
    logic [15:0] yt;
  } cmd_t;

  typedef enum logic [2:0] {
    BK_IDLE, BK_READ, BK_ROW, BK_COL, BK_OUT
  } bk_state_t;

  // round shift by FracBits: add half, then floor (arithmetic shift)
  function automatic logic signed [39:0] rshift(input logic signed [55:0] v);
    logic signed [55:0] w;
    w = v + 56'sd32768;
    rshift = 40'(w >>> FracBits);
  endfunction
endpackage

### design/bir_ram.sv
// bir_ram: generic single-port ram with registered read
// no dependencies
`timescale 1ns / 1ps
module bir_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 65536
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata <= mem[addr];
  end
endmodule

### design/bir_locate.sv
// bir_locate: iterative position divider, one quotient bit per cycle
// depends on bir_pkg
`timescale 1ns / 1ps
module bir_locate
  import bir_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [12:0] dst,
  input  logic [8:0]  srcdim,
  input  logic [12:0] dstdim,
  output logic        done,
  output logic signed [13:0] ipart,
  output logic [15:0] tpart
);
  // q = (2*num + div) / (2*div), num = dst*src<<16 (< 2^38)
  logic [38:0] num_r, num_nxt;
  logic [13:0] div2_r;
  logic [14:0] rem_r, rem_nxt;
  logic [5:0]  cnt_r;
  logic        busy_r;
  logic [39:0] p;
  logic [23:0] ih;
  logic [12:0] dv;
  logic [15:0] tmp;

  assign dv = (dstdim < 13'd2) ? 13'd1 : dstdim - 13'd1;

  always_comb begin
    logic [14:0] r2;
    r2 = {rem_r[13:0], num_r[38]};
    num_nxt = {num_r[37:0], 1'b0};
    rem_nxt = r2;
    if (r2 >= {1'b0, div2_r}) begin
      rem_nxt = r2 - {1'b0, div2_r};
      num_nxt[0] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done <= 1'b0;
      cnt_r <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r <= 6'd39;
      end else if (busy_r) begin
        cnt_r <= cnt_r - 6'd1;
        if (cnt_r == 6'd1) begin
          busy_r <= 1'b0;
          done <= 1'b1;
        end
      end
    end
    if (start) begin
      num_r <= {22'(dst) * 22'(srcdim), 17'd0} + 39'(dv);
      div2_r <= {dv, 1'b0};
      rem_r <= '0;
    end else if (busy_r) begin
      num_r <= num_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign p = {1'b0, num_r} + 40'd32768;
  assign tmp = p[15:0];
  assign ih = p[39:16];
  assign tpart = tmp;
  // integer part saturates well past any edge clamp
  assign ipart = (ih > 24'd4096) ? 14'sd4095 : $signed(ih[13:0]) - 14'sd1;
endmodule

### design/bir_front.sv
// bir_front: accepts items, locates sample positions, fills the queue
// depends on bir_pkg, bir_locate
`timescale 1ns / 1ps
module bir_front
  import bir_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        mode,
  input  logic [7:0]  src_x,
  input  logic [7:0]  src_y,
  input  logic [11:0] dst_x,
  input  logic [11:0] dst_y,
  input  logic [63:0] pix,
  input  logic [8:0]  sw,
  input  logic [8:0]  sh,
  input  logic [12:0] dw,
  input  logic [12:0] dh,
  output logic        q_push,
  output cmd_t        q_data,
  input  logic        q_full
);
  logic busy_r, dx_done_r, dy_done_r;
  logic start;
  logic ddx, ddy;
  logic signed [13:0] xi, yi;
  logic [15:0] xt, yt;
  logic signed [13:0] xi_r, yi_r;
  logic [15:0] xt_r, yt_r;
  logic acc;

  assign in_stall = busy_r | q_full;
  assign acc = in_valid & ~in_stall;
  assign start = acc & (mode == MODE_SAMPLE);

  bir_locate u_lx (.clk, .rst_n, .start, .dst({1'b0, dst_x}), .srcdim(sw),
    .dstdim(dw), .done(ddx), .ipart(xi), .tpart(xt));
  bir_locate u_ly (.clk, .rst_n, .start, .dst({1'b0, dst_y}), .srcdim(sh),
    .dstdim(dh), .done(ddy), .ipart(yi), .tpart(yt));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      dx_done_r <= 1'b0;
      dy_done_r <= 1'b0;
    end else begin
      if (start) busy_r <= 1'b1;
      if (ddx) begin dx_done_r <= 1'b1; xi_r <= xi; xt_r <= xt; end
      if (ddy) begin dy_done_r <= 1'b1; yi_r <= yi; yt_r <= yt; end
      if (q_push && busy_r) begin
        busy_r <= 1'b0;
        dx_done_r <= 1'b0;
        dy_done_r <= 1'b0;
      end
    end
  end

  always_comb begin
    q_data = '0;
    q_push = 1'b0;
    if (acc && mode == MODE_LOAD) begin
      q_push = 1'b1;
      q_data.load = 1'b1;
      q_data.addr = {src_y, src_x};
      q_data.pix = pix;
    end else if (busy_r && dx_done_r && dy_done_r) begin
      q_push = 1'b1;
      q_data.xi = xi_r;
      q_data.yi = yi_r;
      q_data.xt = xt_r;
      q_data.yt = yt_r;
    end
    q_data.xs0 = 8'(sw - 9'd1);
    q_data.ys0 = 8'(sh - 9'd1);
  end
endmodule

### design/bir_back.sv
// bir_back: writes loaded pixels, reads the 4x4 neighborhood and runs the hermite unit
// depends on bir_pkg, bir_ram
`timescale 1ns / 1ps
module bir_back
  import bir_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        q_valid,
  input  cmd_t        q_data,
  output logic        q_pop,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] out_pix
);
  bk_state_t st_r, st_nxt;
  cmd_t cmd_r;
  logic [4:0] rc_r;    // read count 0..16
  logic       rv_r;
  logic [3:0] rv_idx_r;
  logic [63:0] rdata;
  logic        we;
  logic [15:0] addr;
  logic signed [19:0] pv [16][4];
  logic signed [39:0] col [4][4];
  logic [1:0] ri_r, stp_r;
  logic [1:0] ch_r;
  logic signed [39:0] h_r;
  logic signed [39:0] A, B, C, D, ca, cb, cc, cd;
  logic signed [55:0] prod;
  logic [15:0] tt;
  logic [63:0] res_r;
  logic signed [13:0] xc, yc;
  logic [7:0] xs, ys;

  assign we = (st_r == BK_IDLE) && q_valid && q_data.load;
  assign q_pop = (st_r == BK_IDLE) && q_valid;

  always_comb begin
    xc = cmd_r.xi - 14'sd1 + 14'(rc_r[1:0]);
    yc = cmd_r.yi - 14'sd1 + 14'(rc_r[3:2]);
    xs = (xc < 0) ? 8'd0 : (xc > $signed({6'd0, cmd_r.xs0})) ? cmd_r.xs0 : xc[7:0];
    ys = (yc < 0) ? 8'd0 : (yc > $signed({6'd0, cmd_r.ys0})) ? cmd_r.ys0 : yc[7:0];
    addr = we ? q_data.addr : {ys, xs};
  end

  bir_ram #(.WIDTH(64), .DEPTH(65536)) u_ram (.clk, .we, .addr,
    .wdata(q_data.pix), .rdata);

  // operands of the current hermite: row pass uses pixels, column pass uses rows
  always_comb begin
    if (st_r == BK_ROW) begin
      A = 40'(pv[{ri_r, 2'd0}][ch_r]); B = 40'(pv[{ri_r, 2'd1}][ch_r]);
      C = 40'(pv[{ri_r, 2'd2}][ch_r]); D = 40'(pv[{ri_r, 2'd3}][ch_r]);
      tt = cmd_r.xt;
    end else begin
      A = col[0][ch_r]; B = col[1][ch_r]; C = col[2][ch_r]; D = col[3][ch_r];
      tt = cmd_r.yt;
    end
    ca = -A + 3 * B - 3 * C + D;
    cb = 2 * A - 5 * B + 4 * C - D;
    cc = C - A;
    cd = 2 * B;
    prod = 56'(h_r) * $signed({40'd0, tt});
  end

  logic signed [39:0] hn, s;
  logic signed [39:0] fin;
  always_comb begin
    hn = rshift(prod) + (stp_r == 2'd1 ? cb : stp_r == 2'd2 ? cc : cd);
    s = hn + 40'sd1;
    fin = s >>> 1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= BK_IDLE;
      rv_r <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      st_r <= st_nxt;
      rv_r <= (st_r == BK_READ);
      if (st_r == BK_OUT && !out_valid) out_valid <= 1'b1;
      else if (out_valid && !out_stall) out_valid <= 1'b0;
    end
    rv_idx_r <= rc_r[3:0];
    if (rv_r) begin
      for (int k = 0; k < 4; k++) pv[rv_idx_r][k] <= {4'd0, rdata[16*k +: 16]};
    end
    if (st_r == BK_IDLE) begin
      cmd_r <= q_data;
      rc_r <= '0;
    end else if (st_r == BK_READ) rc_r <= rc_r + 5'd1;
    if (st_r != BK_ROW && st_r != BK_COL) begin
      ri_r <= '0; ch_r <= '0; stp_r <= '0;
    end else begin
      if (stp_r == 2'd0) begin
        h_r <= ca; stp_r <= 2'd1;
      end else if (stp_r != 2'd3) begin
        h_r <= hn; stp_r <= stp_r + 2'd1;
      end else begin
        stp_r <= 2'd0;
        if (st_r == BK_ROW) begin
          col[ri_r][ch_r] <= fin;
          ch_r <= ch_r + 2'd1;
          if (ch_r == 2'd3) ri_r <= ri_r + 2'd1;
        end else begin
          res_r[16*ch_r +: 16] <= fin < 0 ? 16'd0 : fin > 40'sd65535 ? 16'hFFFF : fin[15:0];
          ch_r <= ch_r + 2'd1;
        end
      end
    end
  end

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      BK_IDLE: if (q_valid && !q_data.load) st_nxt = BK_READ;
      BK_READ: if (rc_r == 5'd15) st_nxt = BK_ROW;
      BK_ROW:  if (stp_r == 2'd3 && ch_r == 2'd3 && ri_r == 2'd3) st_nxt = BK_COL;
      BK_COL:  if (stp_r == 2'd3 && ch_r == 2'd3) st_nxt = BK_OUT;
      BK_OUT:  if (out_valid && !out_stall) st_nxt = BK_IDLE;
      default: st_nxt = BK_IDLE;
    endcase
  end

  assign out_pix = res_r;
endmodule

### design/bicubic_image_resampler.sv
// bicubic image resampler top: config registers, queue, front and back
// a sample beat is located (two 39-step dividers) and queued, then popped to read the
// 4x4 window from the single-port store and filtered by the shared hermite unit
// (20 curves x 4 steps) before out_valid is registered
// a sample ends before the back pops the next; loads take one beat each unless stalled
// reset: sizes return to 256, store contents undefined until written
`timescale 1ns / 1ps
module bicubic_image_resampler
  import bir_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_mode,
  input  logic [7:0]  in_src_x,
  input  logic [7:0]  in_src_y,
  input  logic [11:0] in_dst_x,
  input  logic [11:0] in_dst_y,
  input  logic [15:0] in_red,
  input  logic [15:0] in_green,
  input  logic [15:0] in_blue,
  input  logic [15:0] in_alpha,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] out_red,
  output logic [15:0] out_green,
  output logic [15:0] out_blue,
  output logic [15:0] out_alpha,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [12:0] cfg_data
);
  logic [8:0]  sw_r, sh_r, sw, sh;
  logic [12:0] dw_r, dh_r;
  cmd_t q_r [2];
  logic [1:0] cnt_r;
  logic q_push, q_pop, q_full;
  cmd_t q_in;
  logic [63:0] pix;

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sw_r <= 9'd256; sh_r <= 9'd256; dw_r <= 13'd256; dh_r <= 13'd256;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_SRC_W: sw_r <= cfg_data[8:0];
        CFG_SRC_H: sh_r <= cfg_data[8:0];
        CFG_DST_W: dw_r <= cfg_data;
        CFG_DST_H: dh_r <= cfg_data;
        default: ;
      endcase
    end
  end
  assign sw = (sw_r == 9'd0) ? 9'd1 : (sw_r > 9'd256) ? 9'd256 : sw_r;
  assign sh = (sh_r == 9'd0) ? 9'd1 : (sh_r > 9'd256) ? 9'd256 : sh_r;

  // two-entry queue, head at index 0
  assign q_full = (cnt_r == 2'd2);
  always_ff @(posedge clk) begin
    if (!rst_n) cnt_r <= '0;
    else cnt_r <= cnt_r + 2'(q_push) - 2'(q_pop);
    if (q_pop) begin
      q_r[0] <= (cnt_r == 2'd2) ? q_r[1] : q_in;
      if (q_push && cnt_r == 2'd2) q_r[1] <= q_in;
    end else if (q_push) begin
      if (cnt_r == 2'd0) q_r[0] <= q_in;
      else q_r[1] <= q_in;
    end
  end

  assign pix = {in_alpha, in_blue, in_green, in_red};

  bir_front u_front (.clk, .rst_n, .in_valid, .in_stall, .mode(in_mode),
    .src_x(in_src_x), .src_y(in_src_y), .dst_x(in_dst_x), .dst_y(in_dst_y),
    .pix, .sw, .sh, .dw(dw_r), .dh(dh_r), .q_push, .q_data(q_in), .q_full);

  logic [63:0] opix;
  bir_back u_back (.clk, .rst_n, .q_valid(cnt_r != 2'd0), .q_data(q_r[0]),
    .q_pop, .out_valid, .out_stall, .out_pix(opix));

  assign out_red = opix[15:0];
  assign out_green = opix[31:16];
  assign out_blue = opix[47:32];
  assign out_alpha = opix[63:48];
endmodule
